// ===== rtl/daubechies4_wavelet_transform_core_assert.svh =====
// Assertion macros for the D4 wavelet transform core checker.
`ifndef DAUBECHIES4_WAVELET_TRANSFORM_CORE_ASSERT_SVH
`define DAUBECHIES4_WAVELET_TRANSFORM_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, idle during reset.
`define D4WT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("d4wt assertion failed");

// Next-cycle implication, clocked on clk_i, idle during reset.
`define D4WT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("d4wt assertion failed");

`endif

// ===== rtl/d4wt_pkg.sv =====
// Shared constants, types and coefficient table of the D4 wavelet transform core.
package d4wt_pkg;

  localparam int MAX_LOG2 = 10;
  localparam int DEPTH    = 1 << MAX_LOG2;
  localparam int ADDR_W   = MAX_LOG2;
  localparam int LEN_W    = MAX_LOG2 + 1;
  localparam int PAIR_W   = MAX_LOG2 - 1;
  localparam int DATA_W   = 32;
  localparam int COEF_W   = 18;
  localparam int PROD_W   = DATA_W + COEF_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int RND_SH   = 16;

  localparam logic REG_DIRECTION   = 1'b0;
  localparam logic REG_LOG2_LENGTH = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic signed [COEF_W-1:0] K0 = 18'sd31651;
  localparam logic signed [COEF_W-1:0] K1 = 18'sd54822;
  localparam logic signed [COEF_W-1:0] K2 = 18'sd14689;
  localparam logic signed [COEF_W-1:0] K3 = -18'sd8481;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MAC,
    ST_COPY
  } d4wt_state_e;

  typedef struct packed {
    logic              io_load;
    logic              io_read;
    logic              out_load;
    logic              fetch;
    logic [1:0]        tap;
    logic              cap;
    logic [1:0]        cap_sel;
    logic              mul;
    logic [2:0]        mul_sel;
    logic              acc;
    logic              acc_first;
    logic              wr_work;
    logic              wr_hi;
    logic              cpy_rd;
    logic              cpy_wr;
    logic [ADDR_W-1:0] cpy_addr;
    logic [PAIR_W-1:0] pair;
    logic [LEN_W-1:0]  len;
    logic              dir;
  } d4wt_cmd_t;

  // sel[2] picks the second filter, sel[1:0] the tap
  function automatic logic signed [COEF_W-1:0] d4wt_coef(input logic dir,
                                                         input logic [2:0] sel);
    logic signed [COEF_W-1:0] c;
    c = K0;
    case ({dir, sel})
      4'b0_000: c = K0;
      4'b0_001: c = K1;
      4'b0_010: c = K2;
      4'b0_011: c = K3;
      4'b0_100: c = K3;
      4'b0_101: c = -K2;
      4'b0_110: c = K1;
      4'b0_111: c = -K0;
      4'b1_000: c = K2;
      4'b1_001: c = K1;
      4'b1_010: c = K0;
      4'b1_011: c = K3;
      4'b1_100: c = K3;
      4'b1_101: c = -K0;
      4'b1_110: c = K1;
      4'b1_111: c = -K2;
      default:  c = K0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/daubechies4_wavelet_transform_core.sv =====
// Top level of the Daubechies-4 wavelet transform core.
// Usage:
//   Slave stream carries items: tuser is the op (load or read), tdata holds
//   index and value, tlast on a load starts the multi-level transform in place
//   over the first 2^log2_length entries once the value is stored.
//   Master stream returns one transfer per read: stored value and its index.
//   Configuration (direction, log2_length) is written through cfg_we_i while idle.
// Timing:
//   A load is written into the value store when it is taken. A read moves
//   from the store's read register into the output register once that is
//   free; the next item is taken as soon as it has moved there, even while
//   the receiver still holds it off. A transform runs levels of length n:
//   every output pair needs four store reads and eight multiply-accumulates on
//   the one shared multiplier, then a copy sweep moves the level back into the
//   value store. s_axis_tready stays low for the whole transform.
// Reset clears control state and sets direction 0, log2_length 10; store
// contents are undefined until written. A stalled receiver holds the result.
module daubechies4_wavelet_transform_core import d4wt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // index[9:0], value[41:10], zero pad
  input  logic        s_axis_tuser,  // op
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // data[31:0], where[41:32], zero pad
);

  d4wt_cmd_t         cmd;
  logic [DATA_W-1:0] out_data;
  logic [ADDR_W-1:0] out_where;

  d4wt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  d4wt_dpath u_dpath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .in_index_i  (s_axis_tdata[ADDR_W-1:0]),
    .in_value_i  (s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W]),
    .out_data_o  (out_data),
    .out_where_o (out_where)
  );

  assign m_axis_tdata = {6'b0, out_where, out_data};

endmodule

// ===== rtl/d4wt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module d4wt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/d4wt_ctrl.sv =====
// Controller: handshakes, configuration registers and the level/pair sequencer.
module d4wt_ctrl import d4wt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  input  logic      in_valid_i,
  input  logic      in_op_i,
  input  logic      in_last_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output d4wt_cmd_t cmd_o
);

  d4wt_state_e       state_q, state_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [PAIR_W-1:0] pair_q, pair_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              dir_q;
  logic [3:0]        log2_q;
  logic              rd_pend_q, rd_pend_d;
  logic              out_valid_q, out_valid_d;

  logic              accept;
  logic              start;
  logic [3:0]        lg_eff;
  logic [LEN_W-1:0]  full_len;
  logic [ADDR_W-1:0] half;
  logic              last_pair;

  assign lg_eff    = (log2_q > 4'(MAX_LOG2)) ? 4'(MAX_LOG2) : log2_q;
  assign full_len  = LEN_W'(1) << lg_eff;
  assign half      = len_q[LEN_W-1:1];
  assign last_pair = ({1'b0, pair_q} == (half - ADDR_W'(1)));

  assign in_ready_o  = (state_q == ST_IDLE) && !rd_pend_q;
  assign accept      = in_valid_i && in_ready_o;
  assign start       = accept && (in_op_i == OP_LOAD) && in_last_i && (log2_q >= 4'd2);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= 1'b0;
      log2_q <= 4'(MAX_LOG2);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DIRECTION:   dir_q  <= cfg_data_i[0];
        REG_LOG2_LENGTH: log2_q <= cfg_data_i;
        default:         dir_q  <= dir_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pair_q      <= '0;
      len_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pair_q      <= pair_d;
      len_q       <= len_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pair_d      = pair_q;
    len_d       = len_q;
    cmd_o       = '0;
    cmd_o.pair  = pair_q;
    cmd_o.len   = len_q;
    cmd_o.dir   = dir_q;

    cmd_o.io_load  = accept && (in_op_i == OP_LOAD);
    cmd_o.io_read  = accept && (in_op_i == OP_READ);
    cmd_o.out_load = rd_pend_q && (!out_valid_q || out_ready_i);

    rd_pend_d   = cmd_o.io_read ? 1'b1 : (cmd_o.out_load ? 1'b0 : rd_pend_q);
    out_valid_d = cmd_o.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_FETCH;
          cnt_d   = '0;
          pair_d  = '0;
          len_d   = dir_q ? LEN_W'(4) : full_len;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch   = (cnt_q < LEN_W'(4));
        cmd_o.tap     = cnt_q[1:0];
        cmd_o.cap     = (cnt_q != '0);
        cmd_o.cap_sel = 2'(cnt_q - LEN_W'(1));
        if (cnt_q == LEN_W'(4)) begin
          state_d = ST_MAC;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + LEN_W'(1);
        end
      end
      ST_MAC: begin
        cmd_o.mul       = (cnt_q < LEN_W'(8));
        cmd_o.mul_sel   = cnt_q[2:0];
        cmd_o.acc       = (cnt_q >= LEN_W'(1)) && (cnt_q <= LEN_W'(8));
        cmd_o.acc_first = (cnt_q == LEN_W'(1)) || (cnt_q == LEN_W'(5));
        cmd_o.wr_work   = (cnt_q == LEN_W'(5)) || (cnt_q == LEN_W'(9));
        cmd_o.wr_hi     = (cnt_q == LEN_W'(9));
        if (cnt_q == LEN_W'(9)) begin
          cnt_d = '0;
          if (last_pair) begin
            state_d = ST_COPY;
          end else begin
            state_d = ST_FETCH;
            pair_d  = pair_q + PAIR_W'(1);
          end
        end else begin
          cnt_d = cnt_q + LEN_W'(1);
        end
      end
      ST_COPY: begin
        cmd_o.cpy_rd   = (cnt_q < len_q);
        cmd_o.cpy_wr   = (cnt_q != '0);
        cmd_o.cpy_addr = cnt_q[ADDR_W-1:0];
        if (cnt_q == len_q) begin
          cnt_d  = '0;
          pair_d = '0;
          if (dir_q ? (len_q == full_len) : (len_q == LEN_W'(4))) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_FETCH;
            len_d   = dir_q ? (len_q << 1) : (len_q >> 1);
          end
        end else begin
          cnt_d = cnt_q + LEN_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/d4wt_dpath.sv =====
// Datapath: value and work stores, address generation, shared MAC and result register.
module d4wt_dpath import d4wt_pkg::*; (
  input  logic              clk_i,
  input  d4wt_cmd_t         cmd_i,
  input  logic [ADDR_W-1:0] in_index_i,
  input  logic [DATA_W-1:0] in_value_i,
  output logic [DATA_W-1:0] out_data_o,
  output logic [ADDR_W-1:0] out_where_o
);

  logic [DATA_W-1:0]        val_rdata, work_rdata;
  logic [ADDR_W-1:0]        val_waddr, val_raddr, work_waddr;
  logic [DATA_W-1:0]        val_wdata;
  logic                     val_we, val_re;
  logic [ADDR_W-1:0]        tap_addr, half, pivot;
  logic [LEN_W-1:0]         fwd_addr, mask;
  logic signed [DATA_W-1:0] v_q [4];
  logic signed [DATA_W-1:0] v_sel;
  logic signed [COEF_W-1:0] coef;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W:0]    rsum;
  logic signed [ACC_W-RND_SH:0] shifted;
  logic [DATA_W-1:0]        result;
  logic [ADDR_W-1:0]        where_pend_q, where_q;
  logic [DATA_W-1:0]        data_q;

  assign half     = cmd_i.len[LEN_W-1:1];
  assign mask     = cmd_i.len - LEN_W'(1);
  assign fwd_addr = (LEN_W'({cmd_i.pair, 1'b0}) + LEN_W'(cmd_i.tap)) & mask;
  assign pivot    = (ADDR_W'(cmd_i.pair) + half - ADDR_W'(1)) & (half - ADDR_W'(1));

  always_comb begin
    tap_addr = fwd_addr[ADDR_W-1:0];
    if (cmd_i.dir) begin
      case (cmd_i.tap)
        2'd0:    tap_addr = pivot;
        2'd1:    tap_addr = pivot + half;
        2'd2:    tap_addr = ADDR_W'(cmd_i.pair);
        2'd3:    tap_addr = ADDR_W'(cmd_i.pair) + half;
        default: tap_addr = pivot;
      endcase
    end
  end

  assign work_waddr = cmd_i.dir ? {cmd_i.pair, cmd_i.wr_hi}
                                : (cmd_i.wr_hi ? ADDR_W'(cmd_i.pair) + half
                                               : ADDR_W'(cmd_i.pair));

  assign val_we    = cmd_i.io_load || cmd_i.cpy_wr;
  assign val_waddr = cmd_i.io_load ? in_index_i : (cmd_i.cpy_addr - ADDR_W'(1));
  assign val_wdata = cmd_i.io_load ? in_value_i : work_rdata;
  assign val_re    = cmd_i.io_read || cmd_i.fetch;
  assign val_raddr = cmd_i.io_read ? in_index_i : tap_addr;

  d4wt_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  d4wt_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_work),
    .waddr_i (work_waddr),
    .wdata_i (result),
    .re_i    (cmd_i.cpy_rd),
    .raddr_i (cmd_i.cpy_addr),
    .rdata_o (work_rdata)
  );

  assign v_sel = v_q[cmd_i.mul_sel[1:0]];
  assign coef  = d4wt_coef(cmd_i.dir, cmd_i.mul_sel);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      v_q[cmd_i.cap_sel] <= val_rdata;
    end
    if (cmd_i.mul) begin
      prod_q <= v_sel * coef;
    end
    if (cmd_i.acc) begin
      acc_q <= cmd_i.acc_first ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
  end

  // round half up by 2^16, then saturate
  assign rsum    = (ACC_W+1)'(acc_q) + (ACC_W+1)'(32768);
  assign shifted = rsum[ACC_W:RND_SH];

  always_comb begin
    if ((&shifted[ACC_W-RND_SH:DATA_W-1]) || !(|shifted[ACC_W-RND_SH:DATA_W-1])) begin
      result = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-RND_SH]) begin
      result = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.io_read) begin
      where_pend_q <= in_index_i;
    end
    if (cmd_i.out_load) begin
      data_q  <= val_rdata;
      where_q <= where_pend_q;
    end
  end

  assign out_data_o  = data_q;
  assign out_where_o = where_q;

endmodule

// ===== rtl/d4wt_checker.sv =====
// Port-level checker for the D4 wavelet transform core, with its bind.
`include "daubechies4_wavelet_transform_core_assert.svh"

module d4wt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  `D4WT_ASSERT_NEXT(a_read_blocks_input, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready)
  `D4WT_ASSERT_NOW(a_result_after_read, $rose(m_axis_tvalid), $past(!s_axis_tready))
  `D4WT_ASSERT_NEXT(a_valid_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `D4WT_ASSERT_NEXT(a_data_holds, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

endmodule

bind daubechies4_wavelet_transform_core d4wt_checker u_d4wt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
